/* sv/alks_pkg.sv */
package alks_pkg;

  // Default converter width
  localparam int unsigned AdcBitsDef = 12;

  // Fixed field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned TicksW = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned EvtW   = 4;

  // Event flag positions inside one key's event nibble
  localparam int unsigned EvtPress  = 0;
  localparam int unsigned EvtShort  = 1;
  localparam int unsigned EvtLong   = 2;
  localparam int unsigned EvtRepeat = 3;

  // Register reset values
  localparam int unsigned UserMaxRst   = 199;
  localparam int unsigned R1MinRst     = 228;
  localparam int unsigned R1MaxRst     = 426;
  localparam int unsigned R2MinRst     = 456;
  localparam int unsigned R2MaxRst     = 682;
  localparam int unsigned LongRst      = 500;
  localparam int unsigned RepeatRst    = 200;
  localparam int unsigned StablePolls0 = 3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegUserMax   = 3'd0,
    RegR1Min     = 3'd1,
    RegR1Max     = 3'd2,
    RegR2Min     = 3'd3,
    RegR2Max     = 3'd4,
    RegLongTime  = 3'd5,
    RegRepeat    = 3'd6,
    RegStable    = 3'd7
  } alks_reg_e;

  // Classified key codes
  typedef enum logic [1:0] {
    KeyNone = 2'd0,
    KeyR1   = 2'd1,
    KeyR2   = 2'd2,
    KeyUser = 2'd3
  } alks_key_e;

  // Timing settings shared by the three key debouncers
  typedef struct packed {
    logic [TicksW-1:0] long_press_time;
    logic [TicksW-1:0] repeat_interval;
    logic [CountW-1:0] stable_polls;
  } alks_key_cfg_t;

endpackage

/* sv/alks_key.sv */
module alks_key (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            idle_i,
  input  logic                            down_i,
  input  logic [alks_pkg::TimeW-1:0]      now_i,
  input  alks_pkg::alks_key_cfg_t         cfg_i,
  output logic [alks_pkg::EvtW-1:0]       events_o
);
  import alks_pkg::*;

  logic              stable_q, stable_d;
  logic              prev_q, prev_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              held_q, held_d;
  logic              long_q, long_d;
  logic [TimeW-1:0]  press_q, press_d;
  logic [TimeW-1:0]  rep_q, rep_d;
  logic              lvl;
  logic [TimeW-1:0]  since_press;
  logic [TimeW-1:0]  since_rep;

  // Debounce, then flag press, short release, long press and repeat
  always_comb begin
    lvl       = ~down_i;
    stable_d  = stable_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    held_d    = held_q;
    long_d    = long_q;
    press_d   = press_q;
    rep_d     = rep_q;
    events_o  = '0;

    if (lvl != prev_q) begin
      cnt_d  = '0;
      prev_d = lvl;
    end else if (cnt_q < cfg_i.stable_polls) begin
      cnt_d = cnt_q + CountW'(1);
    end

    if ((cnt_d >= cfg_i.stable_polls) && (lvl != stable_q)) begin
      stable_d = lvl;
      if (!lvl) begin
        held_d              = 1'b1;
        long_d              = 1'b0;
        press_d             = now_i;
        rep_d               = now_i;
        events_o[EvtPress]  = 1'b1;
      end else begin
        if (held_q && !long_q) begin
          events_o[EvtShort] = 1'b1;
        end
        held_d = 1'b0;
      end
    end

    since_press = now_i - press_d;
    if (held_d && !long_d &&
        (since_press >= {{(TimeW-TicksW){1'b0}}, cfg_i.long_press_time})) begin
      long_d            = 1'b1;
      rep_d             = now_i;
      events_o[EvtLong] = 1'b1;
    end

    since_rep = now_i - rep_d;
    if (held_d && long_d &&
        (since_rep >= {{(TimeW-TicksW){1'b0}}, cfg_i.repeat_interval})) begin
      rep_d               = now_i;
      events_o[EvtRepeat] = 1'b1;
    end

    // Reset action: return to idle, keep the timestamps
    if (idle_i) begin
      stable_d = 1'b1;
      prev_d   = 1'b1;
      cnt_d    = cfg_i.stable_polls;
      held_d   = 1'b0;
      long_d   = 1'b0;
      press_d  = press_q;
      rep_d    = rep_q;
      events_o = '0;
    end
  end

  // Hold key state, advance once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      prev_q   <= 1'b1;
      cnt_q    <= CountW'(StablePolls0);
      held_q   <= 1'b0;
      long_q   <= 1'b0;
      press_q  <= '0;
      rep_q    <= '0;
    end else if (adv_i) begin
      stable_q <= stable_d;
      prev_q   <= prev_d;
      cnt_q    <= cnt_d;
      held_q   <= held_d;
      long_q   <= long_d;
      press_q  <= press_d;
      rep_q    <= rep_d;
    end
  end

endmodule

/* sv/adc_ladder_key_scanner.sv */
// Resistor-ladder key scanner. Each input transaction is one poll: tuser
// carries the action (0 scan, 1 return all keys to idle) and tdata carries
// the ADC code, its valid flag and a millisecond timestamp. The code is
// classified against inclusive windows (USER first, then R1, then R2) and
// three debouncers report press, short release, long press and repeat.
// One poll is taken every clock cycle unless the input side stalls. A poll
// passes an input register and a result register, which loads once any
// waiting result is taken, and is then offered on the master side. While a
// result waits the input register can still take one more poll; after that
// the input side stalls until the waiting result is taken. Configuration
// must be written through the write port while no poll is in flight (the
// block itself does not enforce this) and takes effect on the next poll.
module adc_ladder_key_scanner #(
  parameter int unsigned AdcBits = alks_pkg::AdcBitsDef,
  localparam int unsigned InW    = AdcBits + 1 + alks_pkg::TimeW,
  localparam int unsigned InDW   = ((InW + 7) / 8) * 8,
  localparam int unsigned CfgW   = (AdcBits > alks_pkg::TicksW) ? AdcBits : alks_pkg::TicksW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write port
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  // Poll input
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [InDW-1:0]  s_axis_tdata,  // adc_code, adc_valid, now_ms, zero fill
  input  logic             s_axis_tuser,  // action
  // Event output
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata   // r1_events, r2_events, user_events, raw_key, zero fill
);
  import alks_pkg::*;

  // Configuration registers
  logic [AdcBits-1:0] user_max_q, r1_min_q, r1_max_q, r2_min_q, r2_max_q;
  alks_key_cfg_t      key_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_max_q                <= AdcBits'(UserMaxRst);
      r1_min_q                  <= AdcBits'(R1MinRst);
      r1_max_q                  <= AdcBits'(R1MaxRst);
      r2_min_q                  <= AdcBits'(R2MinRst);
      r2_max_q                  <= AdcBits'(R2MaxRst);
      key_cfg_q.long_press_time <= TicksW'(LongRst);
      key_cfg_q.repeat_interval <= TicksW'(RepeatRst);
      key_cfg_q.stable_polls    <= CountW'(StablePolls0);
    end else if (cfg_we_i) begin
      case (alks_reg_e'(cfg_idx_i))
        RegUserMax:  user_max_q                <= cfg_data_i[AdcBits-1:0];
        RegR1Min:    r1_min_q                  <= cfg_data_i[AdcBits-1:0];
        RegR1Max:    r1_max_q                  <= cfg_data_i[AdcBits-1:0];
        RegR2Min:    r2_min_q                  <= cfg_data_i[AdcBits-1:0];
        RegR2Max:    r2_max_q                  <= cfg_data_i[AdcBits-1:0];
        RegLongTime: key_cfg_q.long_press_time <= cfg_data_i[TicksW-1:0];
        RegRepeat:   key_cfg_q.repeat_interval <= cfg_data_i[TicksW-1:0];
        RegStable:   key_cfg_q.stable_polls    <= cfg_data_i[CountW-1:0];
        default:     ;
      endcase
    end
  end

  // Handshake: the result stage advances on adv; the input register also loads whenever it is empty
  logic in_vld_q, out_vld_q, adv;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign m_axis_tvalid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Input register
  logic               action_q;
  logic [AdcBits-1:0] code_q;
  logic               valid_q;
  logic [TimeW-1:0]   now_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      action_q <= s_axis_tuser;
      code_q   <= s_axis_tdata[AdcBits-1:0];
      valid_q  <= s_axis_tdata[AdcBits];
      now_q    <= s_axis_tdata[AdcBits+TimeW:AdcBits+1];
    end
  end

  // Classify the sample against the code windows
  alks_key_e key;

  always_comb begin
    if (!valid_q) begin
      key = KeyNone;
    end else if (code_q <= user_max_q) begin
      key = KeyUser;
    end else if ((code_q >= r1_min_q) && (code_q <= r1_max_q)) begin
      key = KeyR1;
    end else if ((code_q >= r2_min_q) && (code_q <= r2_max_q)) begin
      key = KeyR2;
    end else begin
      key = KeyNone;
    end
  end

  // Per-key debouncers
  logic [EvtW-1:0] r1_ev, r2_ev, user_ev;

  alks_key u_key_r1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .idle_i   (action_q),
    .down_i   (key == KeyR1),
    .now_i    (now_q),
    .cfg_i    (key_cfg_q),
    .events_o (r1_ev)
  );

  alks_key u_key_r2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .idle_i   (action_q),
    .down_i   (key == KeyR2),
    .now_i    (now_q),
    .cfg_i    (key_cfg_q),
    .events_o (r2_ev)
  );

  alks_key u_key_user (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .idle_i   (action_q),
    .down_i   (key == KeyUser),
    .now_i    (now_q),
    .cfg_i    (key_cfg_q),
    .events_o (user_ev)
  );

  // Result register
  logic [15:0] res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= {2'b00, (action_q ? KeyNone : key), user_ev, r2_ev, r1_ev};
    end
  end

  assign m_axis_tdata = res_q;

endmodule
